/* rtl/core/bei_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bei_pkg
// shared types and constants of the breakpoint envelope interpolator
// ----------------------------------------------------------------------------
package bei_pkg;

	localparam int BEAT_W  = 32;
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = 7;

	// configuration register indexes
	localparam logic REG_CURVE_MODE  = 1'b0;
	localparam logic REG_POINT_COUNT = 1'b1;

	// curve modes
	localparam logic [1:0] MODE_LINEAR = 2'd0;
	localparam logic [1:0] MODE_EXP    = 2'd1;
	localparam logic [1:0] MODE_HOLD   = 2'd2;

	// operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_FIRST,
		ST_SCAN,
		ST_DIV,
		ST_SQR,
		ST_MUL,
		ST_FIN
	} bei_state_t;

endpackage
`default_nettype wire

/* rtl/core/breakpoint_envelope_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// breakpoint table in one synchronous memory, sequential segment search,
// 16-step restoring divider for t, then linear / squared / hold blend
// ----------------------------------------------------------------------------
// write items give no result and busy stays low; evaluate items: an empty table
// finishes without going busy, else the last and first entries are read and a query
// at or outside the ends finishes there; otherwise the segment scan, the divide for t
// and the blend follow (hold mode or a zero span ends at the scan); one item at a time,
// set by the scan through the single memory read port and the one-bit-per-cycle
// divider; done pulses one cycle and cannot be stalled; the next item may start then
// reset clears control state, configuration and done; datapath and table stay undefined
module breakpoint_envelope_interpolator #(
	parameter int MAX_POINTS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire                                operation,
	input  wire  [5:0]                         point_index,
	input  wire  [bei_pkg::BEAT_W-1:0]         point_beat,
	input  wire  signed [bei_pkg::VALUE_W-1:0] point_value,
	input  wire  [bei_pkg::BEAT_W-1:0]         query_beat,
	input  wire                                cfg_we,
	input  wire                                cfg_index,
	input  wire  [bei_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                               done,
	output logic signed [bei_pkg::VALUE_W-1:0] envelope_value
);

	localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int EW = bei_pkg::BEAT_W + bei_pkg::VALUE_W;

	// configuration registers
	logic [1:0]              curve_mode_q;
	logic [bei_pkg::CFG_W-1:0] point_count_q;

	// control
	bei_pkg::bei_state_t state_q, state_d;
	logic [AW-1:0]       idx_q;
	logic [4:0]          cnt_q;

	// datapath
	logic [bei_pkg::BEAT_W-1:0]         q_q;
	logic [bei_pkg::BEAT_W-1:0]         last_beat_q;
	logic [bei_pkg::VALUE_W-1:0]        last_val_q;
	logic [bei_pkg::BEAT_W-1:0]         a_q;
	logic signed [bei_pkg::VALUE_W-1:0] va_q;
	logic [bei_pkg::BEAT_W-1:0]         den_q;
	logic [bei_pkg::BEAT_W-1:0]         rem_q;
	logic [bei_pkg::FRAC_W:0]           t_q;
	logic signed [bei_pkg::VALUE_W:0]   diff_q;
	logic signed [bei_pkg::VALUE_W+bei_pkg::FRAC_W+1:0] prod_q;

	// table memory: {beat, value} per entry
	logic [EW-1:0] mem_q [MAX_POINTS];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] rd_addr_c;

	logic                              accept_c;
	logic [NW-1:0]                     n_c;
	logic [bei_pkg::BEAT_W-1:0]        beat_r;
	logic signed [bei_pkg::VALUE_W-1:0] val_r;
	logic                              match_c;
	logic                              scan_end_c;
	logic                              fin_c;
	logic [bei_pkg::VALUE_W-1:0]       fin_val_c;
	logic [bei_pkg::BEAT_W:0]          rem2_c;
	logic [2*bei_pkg::FRAC_W+1:0]      sq_c;
	logic                              done_q;
	logic [bei_pkg::VALUE_W-1:0]       env_q;

	assign accept_c   = start && !busy;
	assign beat_r     = rdata_q[EW-1:bei_pkg::VALUE_W];
	assign val_r      = $signed(rdata_q[bei_pkg::VALUE_W-1:0]);
	assign match_c    = (q_q >= a_q) && (q_q <= beat_r);
	assign scan_end_c = (idx_q == AW'(n_c - 1'b1));
	assign rem2_c     = {rem_q, 1'b0};
	assign sq_c       = t_q * t_q;
	assign busy       = (state_q != bei_pkg::ST_IDLE);
	assign done       = done_q;
	assign envelope_value = $signed(env_q);

	// point count saturates at the table depth
	always_comb begin
		if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			n_c = NW'(MAX_POINTS);
		end else begin
			n_c = NW'(point_count_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bei_pkg::ST_IDLE: begin
				if (accept_c && operation == bei_pkg::OP_EVAL && n_c != '0) begin
					state_d = bei_pkg::ST_LAST;
				end
			end
			bei_pkg::ST_LAST: state_d = bei_pkg::ST_FIRST;
			bei_pkg::ST_FIRST: begin
				priority if (q_q <= beat_r || q_q >= last_beat_q) begin
					state_d = bei_pkg::ST_IDLE;
				end else begin
					state_d = bei_pkg::ST_SCAN;
				end
			end
			bei_pkg::ST_SCAN: begin
				priority if (match_c) begin
					if (curve_mode_q == bei_pkg::MODE_HOLD || beat_r == a_q) begin
						state_d = bei_pkg::ST_IDLE;
					end else begin
						state_d = bei_pkg::ST_DIV;
					end
				end else if (scan_end_c) begin
					state_d = bei_pkg::ST_IDLE;
				end
			end
			bei_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = (curve_mode_q == bei_pkg::MODE_EXP) ?
						bei_pkg::ST_SQR : bei_pkg::ST_MUL;
				end
			end
			bei_pkg::ST_SQR: state_d = bei_pkg::ST_MUL;
			bei_pkg::ST_MUL: state_d = bei_pkg::ST_FIN;
			bei_pkg::ST_FIN: state_d = bei_pkg::ST_IDLE;
			default: state_d = bei_pkg::ST_IDLE;
		endcase
	end

	// outputs: read address and finish strobe
	always_comb begin
		rd_addr_c = idx_q + 1'b1;
		fin_c     = 1'b0;
		fin_val_c = '0;
		unique case (state_q)
			bei_pkg::ST_IDLE: begin
				rd_addr_c = AW'(n_c - 1'b1);
				if (accept_c && operation == bei_pkg::OP_EVAL && n_c == '0) begin
					fin_c = 1'b1;
				end
			end
			bei_pkg::ST_LAST: rd_addr_c = '0;
			bei_pkg::ST_FIRST: begin
				rd_addr_c = AW'(1);
				priority if (q_q <= beat_r) begin
					fin_c     = 1'b1;
					fin_val_c = val_r;
				end else if (q_q >= last_beat_q) begin
					fin_c     = 1'b1;
					fin_val_c = last_val_q;
				end
			end
			bei_pkg::ST_SCAN: begin
				priority if (match_c) begin
					if (curve_mode_q == bei_pkg::MODE_HOLD || beat_r == a_q) begin
						fin_c     = 1'b1;
						fin_val_c = va_q;
					end
				end else if (scan_end_c) begin
					fin_c     = 1'b1;
					fin_val_c = last_val_q;
				end
			end
			bei_pkg::ST_FIN: begin
				fin_c     = 1'b1;
				fin_val_c = va_q + prod_q[bei_pkg::VALUE_W+bei_pkg::FRAC_W-1:bei_pkg::FRAC_W];
			end
			default: ;
		endcase
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (accept_c && operation == bei_pkg::OP_WRITE && 32'(point_index) < 32'(MAX_POINTS))
		begin
			mem_q[AW'(point_index)] <= {point_beat, point_value};
		end
		rdata_q <= mem_q[rd_addr_c];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bei_pkg::ST_IDLE;
			curve_mode_q  <= bei_pkg::MODE_LINEAR;
			point_count_q <= '0;
			done_q        <= 1'b0;
			idx_q         <= '0;
			cnt_q         <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin_c;
			if (cfg_we) begin
				unique case (cfg_index)
					bei_pkg::REG_CURVE_MODE:  curve_mode_q  <= cfg_wdata[1:0];
					bei_pkg::REG_POINT_COUNT: point_count_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == bei_pkg::ST_FIRST) begin
				idx_q <= AW'(1);
			end else if (state_q == bei_pkg::ST_SCAN && !match_c) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == bei_pkg::ST_SCAN && match_c) begin
				// exact hit on the far end gives t = 1.0 with no division
				cnt_q <= (q_q == beat_r) ? 5'd0 : 5'(bei_pkg::FRAC_W);
			end else if (state_q == bei_pkg::ST_DIV && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin_c) begin
			env_q <= fin_val_c;
		end
		if (accept_c) begin
			q_q <= query_beat;
		end
		unique case (state_q)
			bei_pkg::ST_LAST: begin
				last_beat_q <= beat_r;
				last_val_q  <= val_r;
			end
			bei_pkg::ST_FIRST: begin
				a_q  <= beat_r;
				va_q <= val_r;
			end
			bei_pkg::ST_SCAN: begin
				if (match_c) begin
					den_q  <= beat_r - a_q;
					rem_q  <= q_q - a_q;
					diff_q <= 33'(val_r) - 33'(va_q);
					t_q    <= (q_q == beat_r) ? 17'h10000 : '0;
				end else begin
					a_q  <= beat_r;
					va_q <= val_r;
				end
			end
			bei_pkg::ST_DIV: begin
				// restoring divide, one quotient bit a cycle
				if (cnt_q != '0) begin
					if (rem2_c >= {1'b0, den_q}) begin
						rem_q <= 32'(rem2_c - {1'b0, den_q});
						t_q   <= {t_q[bei_pkg::FRAC_W-1:0], 1'b1};
					end else begin
						rem_q <= rem2_c[bei_pkg::BEAT_W-1:0];
						t_q   <= {t_q[bei_pkg::FRAC_W-1:0], 1'b0};
					end
				end
			end
			bei_pkg::ST_SQR: t_q <= sq_c[2*bei_pkg::FRAC_W:bei_pkg::FRAC_W];
			bei_pkg::ST_MUL: prod_q <= diff_q * $signed({1'b0, t_q});
			default: ;
		endcase
	end

	// result strobe only follows evaluate work or an evaluate on an empty table
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without evaluate work");

	// divider remainder stays below the span
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bei_pkg::ST_DIV && cnt_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	// t never exceeds one
	a_t_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bei_pkg::ST_MUL) |-> (t_q <= 17'h10000))
		else $error("interpolation fraction above one");

	// an evaluate on a filled table makes the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_c && operation == bei_pkg::OP_EVAL && n_c != '0) |=> busy)
		else $error("evaluate transfer not started");

endmodule
`default_nettype wire
